// ----- rtl/core/assert_macros.svh -----
// Assertion macros shared by the curve evaluator RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define CBZ_ASSERT_IMP(name, clk, rst, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define CBZ_ASSERT_NXT(name, clk, rst, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/core/cbz_pkg.sv -----
// Shared constants and types of the cubic Bezier point evaluator.
`default_nettype none

package cbz_pkg;

  localparam int FRAC_BITS    = 16;
  localparam int Q_W          = FRAC_BITS + 1;
  localparam int COORD_WIDTH  = 16;
  localparam int POINT_W      = 3 * COORD_WIDTH;
  localparam int IDX_W        = 11;
  localparam int MAX_INTERVAL = 1024;
  localparam int TPROD_W      = IDX_W + Q_W;
  localparam int SQ_W         = 2 * Q_W;
  localparam int TRI_W        = 2 * Q_W + 2;
  localparam int PROD_W       = Q_W + 1 + COORD_WIDTH;
  localparam int ACC_W        = PROD_W + 2;
  localparam int QUEUE_DEPTH  = 4;
  localparam int QPTR_W       = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W       = QPTR_W + 1;
  localparam int CFG_IDX_W    = 3;

  localparam logic [Q_W-1:0] ONE_Q  = {1'b1, {FRAC_BITS{1'b0}}};
  localparam logic [Q_W-1:0] HALF_Q = {2'b01, {(FRAC_BITS - 1){1'b0}}};

  localparam logic signed [COORD_WIDTH-1:0] FLAG_COORD = COORD_WIDTH'(-10000);

  localparam logic [IDX_W-1:0] INTERVAL_RESET = IDX_W'(200);
  localparam logic [Q_W-1:0]   STEP_RESET     = Q_W'(328);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_POINT_A        = 3'd0,
    REG_POINT_B        = 3'd1,
    REG_POINT_C        = 3'd2,
    REG_POINT_D        = 3'd3,
    REG_INTERVAL_COUNT = 3'd4,
    REG_STEP_FRACTION  = 3'd5
  } cfg_reg_t;

  // One classified request on its way from the front to the back.
  typedef struct packed {
    logic           out_of_range;
    logic [Q_W-1:0] t;
  } cbz_item_t;

  // Head of the queue as the back end sees it.
  typedef struct packed {
    logic      valid;
    cbz_item_t item;
  } cbz_head_t;

  typedef logic [3:0][POINT_W-1:0] cbz_points_t;

endpackage

`default_nettype wire

// ----- rtl/core/cbz_front.sv -----
// Front end: takes sample indices, flags out-of-range ones and forms t.
`default_nettype none

module cbz_front (
  input  wire logic [cbz_pkg::IDX_W-1:0] sample_index,
  input  wire logic [cbz_pkg::IDX_W-1:0] interval_count,
  input  wire logic [cbz_pkg::Q_W-1:0]   step_fraction,
  output cbz_pkg::cbz_item_t             item
);

  logic [cbz_pkg::TPROD_W-1:0] t_prod;
  logic [cbz_pkg::IDX_W-1:0]   limit;

  always_comb begin
    // Counts above the supported maximum behave as the maximum.
    if (interval_count > cbz_pkg::IDX_W'(cbz_pkg::MAX_INTERVAL)) begin
      limit = cbz_pkg::IDX_W'(cbz_pkg::MAX_INTERVAL);
    end else begin
      limit = interval_count;
    end
    t_prod = cbz_pkg::TPROD_W'(sample_index) * cbz_pkg::TPROD_W'(step_fraction);
    item.out_of_range = (sample_index > limit);
    if (t_prod > cbz_pkg::TPROD_W'(cbz_pkg::ONE_Q)) begin
      item.t = cbz_pkg::ONE_Q;
    end else begin
      item.t = t_prod[cbz_pkg::Q_W-1:0];
    end
  end

endmodule

`default_nettype wire

// ----- rtl/core/cbz_queue.sv -----
// Short queue that decouples the front end from the evaluation pipeline.
`default_nettype none
`include "assert_macros.svh"

module cbz_queue (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           push,
  input  wire cbz_pkg::cbz_item_t push_item,
  output logic                full,
  input  wire logic           pop,
  output cbz_pkg::cbz_head_t  head
);

  cbz_pkg::cbz_item_t mem [cbz_pkg::QUEUE_DEPTH];

  logic [cbz_pkg::QPTR_W-1:0] wr_ptr;
  logic [cbz_pkg::QPTR_W-1:0] rd_ptr;
  logic [cbz_pkg::QCNT_W-1:0] count;
  logic                       push_ok;
  logic                       pop_ok;

  assign full    = (count == cbz_pkg::QCNT_W'(cbz_pkg::QUEUE_DEPTH));
  assign push_ok = push && !full;
  assign pop_ok  = pop && (count != '0);

  assign head.valid = (count != '0);
  assign head.item  = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push_ok) begin
      mem[wr_ptr] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push_ok) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop_ok) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push_ok && !pop_ok) begin
        count <= count + 1'b1;
      end else if (pop_ok && !push_ok) begin
        count <= count - 1'b1;
      end
    end
  end

  `CBZ_ASSERT_IMP(a_count_bound, clk, rst, 1'b1,
    count <= cbz_pkg::QCNT_W'(cbz_pkg::QUEUE_DEPTH), "queue count beyond depth")
  `CBZ_ASSERT_NXT(a_push_grows, clk, rst, push_ok && !pop_ok,
    count == $past(count) + 1'b1, "push without pop did not grow the queue")

endmodule

`default_nettype wire

// ----- rtl/core/cbz_back.sv -----
// Back end: Bernstein weights, weighted sums, rounding and saturation, or flag coordinates for out-of-range items.
`default_nettype none
`include "assert_macros.svh"

module cbz_back (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire cbz_pkg::cbz_head_t  head,
  output logic                     pop,
  input  wire cbz_pkg::cbz_points_t points,
  output logic                     out_valid,
  input  wire logic                out_stall,
  output logic signed [cbz_pkg::COORD_WIDTH-1:0] pos_x,
  output logic signed [cbz_pkg::COORD_WIDTH-1:0] pos_y,
  output logic signed [cbz_pkg::COORD_WIDTH-1:0] pos_z,
  output logic                     out_of_range
);

  localparam int QW = cbz_pkg::Q_W;
  localparam int FB = cbz_pkg::FRAC_BITS;
  localparam int CW = cbz_pkg::COORD_WIDTH;

  logic advance;

  logic s1_valid, s2_valid, s3_valid, s4_valid, s5_valid;
  logic s1_oor, s2_oor, s3_oor, s4_oor, s5_oor;

  logic [QW-1:0] s1_t, s1_u;
  logic [QW-1:0] s2_t, s2_u, s2_tt, s2_uu;
  logic [QW-1:0] s3_w [4];
  logic signed [cbz_pkg::PROD_W-1:0] s4_prod [3][4];
  logic signed [cbz_pkg::ACC_W-1:0]  s5_acc [3];

  logic [cbz_pkg::SQ_W-1:0]  tt_full, uu_full, w0_full, w3_full;
  logic [cbz_pkg::TRI_W-1:0] tuu, ttu, w1_full, w2_full;
  logic signed [CW-1:0]      coord [4][3];
  logic signed [cbz_pkg::ACC_W-1:0] rounded [3];
  logic signed [CW-1:0]      sat [3];

  // Every stage moves together unless the output holds an untaken result.
  assign advance = !out_valid || !out_stall;
  assign pop     = advance;

  always_comb begin
    tt_full = cbz_pkg::SQ_W'(s1_t) * cbz_pkg::SQ_W'(s1_t) + cbz_pkg::SQ_W'(cbz_pkg::HALF_Q);
    uu_full = cbz_pkg::SQ_W'(s1_u) * cbz_pkg::SQ_W'(s1_u) + cbz_pkg::SQ_W'(cbz_pkg::HALF_Q);
    w0_full = cbz_pkg::SQ_W'(s2_uu) * cbz_pkg::SQ_W'(s2_u) + cbz_pkg::SQ_W'(cbz_pkg::HALF_Q);
    w3_full = cbz_pkg::SQ_W'(s2_tt) * cbz_pkg::SQ_W'(s2_t) + cbz_pkg::SQ_W'(cbz_pkg::HALF_Q);
    tuu     = cbz_pkg::TRI_W'(s2_t) * cbz_pkg::TRI_W'(s2_uu);
    ttu     = cbz_pkg::TRI_W'(s2_tt) * cbz_pkg::TRI_W'(s2_u);
    // Times three as a shift and add.
    w1_full = tuu + (tuu << 1) + cbz_pkg::TRI_W'(cbz_pkg::HALF_Q);
    w2_full = ttu + (ttu << 1) + cbz_pkg::TRI_W'(cbz_pkg::HALF_Q);
  end

  always_comb begin
    for (int k = 0; k < 4; k++) begin
      for (int a = 0; a < 3; a++) begin
        coord[k][a] = points[k][a*CW +: CW];
      end
    end
  end

  always_comb begin
    for (int a = 0; a < 3; a++) begin
      rounded[a] = (s5_acc[a] + $signed(cbz_pkg::ACC_W'(cbz_pkg::HALF_Q))) >>> FB;
      if (rounded[a] > cbz_pkg::ACC_W'((1 << (CW - 1)) - 1)) begin
        sat[a] = {1'b0, {(CW - 1){1'b1}}};
      end else if (rounded[a] < -(cbz_pkg::ACC_W'(1) << (CW - 1))) begin
        sat[a] = {1'b1, {(CW - 1){1'b0}}};
      end else begin
        sat[a] = rounded[a][CW-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      s2_valid  <= 1'b0;
      s3_valid  <= 1'b0;
      s4_valid  <= 1'b0;
      s5_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else if (advance) begin
      s1_valid  <= head.valid;
      s2_valid  <= s1_valid;
      s3_valid  <= s2_valid;
      s4_valid  <= s3_valid;
      s5_valid  <= s4_valid;
      out_valid <= s5_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      s1_oor <= head.item.out_of_range;
      s1_t   <= head.item.t;
      s1_u   <= cbz_pkg::ONE_Q - head.item.t;

      s2_oor <= s1_oor;
      s2_t   <= s1_t;
      s2_u   <= s1_u;
      s2_tt  <= tt_full[FB +: QW];
      s2_uu  <= uu_full[FB +: QW];

      s3_oor  <= s2_oor;
      s3_w[0] <= w0_full[FB +: QW];
      s3_w[1] <= w1_full[FB +: QW];
      s3_w[2] <= w2_full[FB +: QW];
      s3_w[3] <= w3_full[FB +: QW];

      s4_oor <= s3_oor;
      for (int a = 0; a < 3; a++) begin
        for (int k = 0; k < 4; k++) begin
          s4_prod[a][k] <= $signed({1'b0, s3_w[k]}) * coord[k][a];
        end
      end

      s5_oor <= s4_oor;
      for (int a = 0; a < 3; a++) begin
        s5_acc[a] <= cbz_pkg::ACC_W'(s4_prod[a][0]) + cbz_pkg::ACC_W'(s4_prod[a][1])
                   + cbz_pkg::ACC_W'(s4_prod[a][2]) + cbz_pkg::ACC_W'(s4_prod[a][3]);
      end

      out_of_range <= s5_oor;
      if (s5_oor) begin
        pos_x <= cbz_pkg::FLAG_COORD;
        pos_y <= cbz_pkg::FLAG_COORD;
        pos_z <= cbz_pkg::FLAG_COORD;
      end else begin
        pos_x <= sat[0];
        pos_y <= sat[1];
        pos_z <= sat[2];
      end
    end
  end

  `CBZ_ASSERT_IMP(a_flag_coords, clk, rst, out_valid && out_of_range,
    pos_x == cbz_pkg::FLAG_COORD && pos_y == cbz_pkg::FLAG_COORD
    && pos_z == cbz_pkg::FLAG_COORD, "out-of-range result without flag coordinates")

endmodule

`default_nettype wire

// ----- rtl/core/cubic_bezier_point_eval.sv -----
// Top level of the cubic Bezier point evaluator.
`default_nettype none

// Evaluates a 3D cubic Bezier curve at one sample index per transaction. The
// control points, interval count and parameter step are to be written through
// the plain configuration port while the block is idle; the block itself does
// not enforce this. Each accepted index is turned into t = index * step
// (clamped to 1.0) in the front end in the cycle it arrives, classified
// as in or out of range, and placed in a four-entry queue. The back end is
// a six-stage pipeline: u = 1 - t, the squares tt and uu, the four
// Bernstein weights, twelve weight-by-coordinate products (one lane per
// axis and control point), the per-axis sums, and rounding with saturation
// into the output register. Sustained throughput is one point per clock
// while the output is not stalled. A stall on the output freezes the whole
// pipeline, and the input keeps taking transactions until the queue is
// full, so the input stall rises only once the queue has filled behind the
// held output. Indices beyond the interval count (capped at 1024) give
// the value -10000 on every axis with out_of_range set.

module cubic_bezier_point_eval (
  input  wire logic                                clk,
  input  wire logic                                rst,

  input  wire logic                                cfg_write,
  input  wire logic [cbz_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  wire logic [cbz_pkg::POINT_W-1:0]         cfg_data,

  input  wire logic                                in_valid,
  output logic                                     in_stall,
  input  wire logic [cbz_pkg::IDX_W-1:0]           sample_index,

  output logic                                     out_valid,
  input  wire logic                                out_stall,
  output logic signed [cbz_pkg::COORD_WIDTH-1:0]   pos_x,
  output logic signed [cbz_pkg::COORD_WIDTH-1:0]   pos_y,
  output logic signed [cbz_pkg::COORD_WIDTH-1:0]   pos_z,
  output logic                                     out_of_range
);

  cbz_pkg::cbz_points_t            points;
  logic [cbz_pkg::IDX_W-1:0]       interval_count;
  logic [cbz_pkg::Q_W-1:0]         step_fraction;

  cbz_pkg::cbz_item_t front_item;
  cbz_pkg::cbz_head_t queue_head;
  logic               queue_full;
  logic               back_pop;

  // Configuration registers. Data is truncated to each register's width and
  // writes to unused indices fall through the default arm.
  always_ff @(posedge clk) begin
    if (rst) begin
      points         <= '0;
      interval_count <= cbz_pkg::INTERVAL_RESET;
      step_fraction  <= cbz_pkg::STEP_RESET;
    end else if (cfg_write) begin
      case (cfg_index)
        cbz_pkg::REG_POINT_A:        points[0] <= cfg_data;
        cbz_pkg::REG_POINT_B:        points[1] <= cfg_data;
        cbz_pkg::REG_POINT_C:        points[2] <= cfg_data;
        cbz_pkg::REG_POINT_D:        points[3] <= cfg_data;
        cbz_pkg::REG_INTERVAL_COUNT: interval_count <= cfg_data[cbz_pkg::IDX_W-1:0];
        cbz_pkg::REG_STEP_FRACTION:  step_fraction <= cfg_data[cbz_pkg::Q_W-1:0];
        default: ;
      endcase
    end
  end

  // The input stalls only when the queue has no free entry.
  assign in_stall = queue_full;

  cbz_front u_front (
    .sample_index   (sample_index),
    .interval_count (interval_count),
    .step_fraction  (step_fraction),
    .item           (front_item)
  );

  cbz_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (in_valid),
    .push_item (front_item),
    .full      (queue_full),
    .pop       (back_pop),
    .head      (queue_head)
  );

  cbz_back u_back (
    .clk          (clk),
    .rst          (rst),
    .head         (queue_head),
    .pop          (back_pop),
    .points       (points),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .pos_x        (pos_x),
    .pos_y        (pos_y),
    .pos_z        (pos_z),
    .out_of_range (out_of_range)
  );

endmodule

`default_nettype wire
